// ===== rtl/bounded_list_table_assert.svh =====
// Assertion macros for the list table. Empty bodies in synthesis.
`ifndef BOUNDED_LIST_TABLE_ASSERT_SVH
`define BOUNDED_LIST_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define BLT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BLT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define BLT_ASSERT(lbl, clk, rstn, prop, msg)
`define BLT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/blt_pkg.sv =====
package blt_pkg;

	localparam int CMD_W      = 2;
	localparam int ITEM_W     = 32;
	localparam int POS_W      = 4;
	localparam int STAT_W     = 2;
	localparam int TDATA_W    = 40;
	localparam int TPAD_W     = TDATA_W - ITEM_W - POS_W;
	localparam int EXT_W      = 64;
	localparam int CNT_EXT_W  = 7;
	localparam int MAX_RESULTS = 16;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

	typedef struct packed {
		logic [ITEM_W-1:0] item_value;
		logic [POS_W-1:0]  position;
		logic [STAT_W-1:0] status;
		logic              last;
	} res_t;

endpackage

// ===== rtl/blt_mem.sv =====
module blt_mem #(
	parameter int DEPTH,
	parameter int WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/blt_out.sv =====
module blt_out import blt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ld,
	input  res_t               res,
	output logic               free,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [STAT_W-1:0]  m_tuser,
	output logic               m_tlast
);

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{TPAD_W{1'b0}}, res_q.position, res_q.item_value};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule

// ===== rtl/blt_ctrl.sv =====
`include "bounded_list_table_assert.svh"

module blt_ctrl import blt_pkg::*; #(
	parameter int CAPACITY,
	parameter int DATA_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [CMD_W-1:0]            cmd,
	input  logic [ITEM_W-1:0]           value,
	output logic                        rd_en,
	output logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [DATA_WIDTH-1:0]       rdata,
	output logic                        we,
	output logic [$clog2(CAPACITY)-1:0] waddr,
	output logic [DATA_WIDTH-1:0]       wdata,
	output logic                        res_ld,
	output res_t                        res,
	input  logic                        res_free
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SCAN_RD = 4'd1;
	localparam logic [3:0] ST_SCAN_CK = 4'd2;
	localparam logic [3:0] ST_ISH_RD  = 4'd3;
	localparam logic [3:0] ST_ISH_WR  = 4'd4;
	localparam logic [3:0] ST_PLACE   = 4'd5;
	localparam logic [3:0] ST_DSH_RD  = 4'd6;
	localparam logic [3:0] ST_DSH_WR  = 4'd7;
	localparam logic [3:0] ST_DUMP_RD = 4'd8;
	localparam logic [3:0] ST_DUMP_EM = 4'd9;
	localparam logic [3:0] ST_RESP    = 4'd10;

	logic [3:0]            state_q, state_d;
	logic [CMD_W-1:0]      cmd_q, cmd_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic [CW-1:0]         idx_q, idx_d;
	logic [CW-1:0]         pos_q, pos_d;
	logic [CW-1:0]         count_q, count_d;
	logic [STAT_W-1:0]     stat_q, stat_d;
	logic                  inc_q, inc_d;
	logic                  dec_q, dec_d;

	logic [EXT_W-1:0]      in_ext;
	logic [EXT_W-1:0]      out_ext;
	logic [CW-1:0]         idx_nxt;
	logic [CW-1:0]         idx_prv;
	logic [CNT_EXT_W-1:0]  idx_x;
	logic                  full;
	logic                  dump_last;
	logic                  e_gt, e_ge, e_eq;

	assign in_ext    = EXT_W'(signed'(value));
	assign out_ext   = EXT_W'(signed'((state_q == ST_DUMP_EM) ? rdata : val_q));
	assign idx_nxt   = idx_q + 1'b1;
	assign idx_prv   = idx_q - 1'b1;
	assign idx_x     = CNT_EXT_W'(idx_q) + 1'b1;
	assign full      = (count_q == CW'(CAPACITY));
	assign dump_last = (idx_x == CNT_EXT_W'(count_q)) || (idx_x == CNT_EXT_W'(MAX_RESULTS));
	assign e_gt      = $signed(rdata) > $signed(val_q);
	assign e_ge      = $signed(rdata) >= $signed(val_q);
	assign e_eq      = (rdata == val_q);

	assign s_tready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		val_d   = val_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		count_d = count_q;
		stat_d  = stat_q;
		inc_d   = inc_q;
		dec_d   = dec_q;
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		we      = 1'b0;
		waddr   = idx_q[AW-1:0];
		wdata   = rdata;
		res_ld  = 1'b0;

		res.item_value = out_ext[ITEM_W-1:0];
		res.position   = POS_W'(pos_q);
		res.status     = stat_q;
		res.last       = 1'b1;
		if (state_q == ST_DUMP_EM) begin
			res.position = POS_W'(idx_q);
			res.status   = STAT_OK;
			res.last     = dump_last;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd_d  = cmd;
					val_d  = (cmd == CMD_DUMP) ? '0 : in_ext[DATA_WIDTH-1:0];
					idx_d  = '0;
					pos_d  = '0;
					inc_d  = 1'b0;
					dec_d  = 1'b0;
					stat_d = STAT_OK;
					unique case (cmd)
						CMD_APPEND, CMD_INSERT: begin
							if (full) begin
								stat_d  = STAT_FULL;
								state_d = ST_RESP;
							end else if (cmd == CMD_APPEND || count_q == '0) begin
								pos_d   = count_q;
								state_d = ST_PLACE;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						CMD_DELETE: begin
							if (count_q == '0) begin
								stat_d  = STAT_NOT_FOUND;
								state_d = ST_RESP;
							end else begin
								state_d = ST_SCAN_RD;
							end
						end
						CMD_DUMP: begin
							if (count_q == '0) begin
								stat_d  = STAT_EMPTY;
								state_d = ST_RESP;
							end else begin
								state_d = ST_DUMP_RD;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN_RD: begin
				rd_en   = 1'b1;
				state_d = ST_SCAN_CK;
			end
			ST_SCAN_CK: begin
				if (cmd_q == CMD_DELETE) begin
					if (e_eq) begin
						pos_d   = idx_q;
						state_d = ST_DSH_RD;
					end else if (idx_nxt == count_q) begin
						stat_d  = STAT_NOT_FOUND;
						state_d = ST_RESP;
					end else begin
						idx_d   = idx_nxt;
						state_d = ST_SCAN_RD;
					end
				end else begin
					// head goes first only when strictly greater
					if ((idx_q == '0) ? e_gt : e_ge) begin
						pos_d   = idx_q;
						idx_d   = count_q;
						state_d = ST_ISH_RD;
					end else if (idx_nxt == count_q) begin
						pos_d   = count_q;
						state_d = ST_PLACE;
					end else begin
						idx_d   = idx_nxt;
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_ISH_RD: begin
				if (idx_q == pos_q) begin
					state_d = ST_PLACE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_prv[AW-1:0];
					state_d = ST_ISH_WR;
				end
			end
			ST_ISH_WR: begin
				we      = 1'b1;
				idx_d   = idx_prv;
				state_d = ST_ISH_RD;
			end
			ST_PLACE: begin
				we      = 1'b1;
				waddr   = pos_q[AW-1:0];
				wdata   = val_q;
				inc_d   = 1'b1;
				state_d = ST_RESP;
			end
			ST_DSH_RD: begin
				if (idx_nxt == count_q) begin
					dec_d   = 1'b1;
					state_d = ST_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_nxt[AW-1:0];
					state_d = ST_DSH_WR;
				end
			end
			ST_DSH_WR: begin
				we      = 1'b1;
				idx_d   = idx_nxt;
				state_d = ST_DSH_RD;
			end
			ST_DUMP_RD: begin
				rd_en   = 1'b1;
				state_d = ST_DUMP_EM;
			end
			ST_DUMP_EM: begin
				if (res_free) begin
					res_ld = 1'b1;
					if (dump_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_nxt;
						state_d = ST_DUMP_RD;
					end
				end
			end
			ST_RESP: begin
				if (res_free) begin
					res_ld  = 1'b1;
					count_d = count_q + CW'(inc_q) - CW'(dec_q);
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			inc_q   <= 1'b0;
			dec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			inc_q   <= inc_d;
			dec_q   <= dec_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		val_q  <= val_d;
		idx_q  <= idx_d;
		pos_q  <= pos_d;
		stat_q <= stat_d;
	end

	`BLT_NEVER(a_count_max, clk, arst_n, count_q > CW'(CAPACITY), "entry count above capacity")
	`BLT_ASSERT(a_count_step, clk, arst_n, (count_q != $past(count_q)) |-> $past(res_ld), "count moved without a result")
	`BLT_ASSERT(a_res_next, clk, arst_n, res_ld |=> (state_q == ST_IDLE || state_q == ST_DUMP_RD), "bad state after result")

endmodule

// ===== rtl/bounded_list_table.sv =====
// channel | dir | tdata (low bit up)            | tuser         | tlast
// s_*     | in  | value[31:0]                   | command[1:0]  | -
// m_*     | out | item_value[31:0], position[3:0], 4'b0 pad | status[1:0] | last
//
// One transaction at a time. Append writes the value at the tail. Insert and
// delete scan the entries in order, each read followed by its check, then shift
// the entries behind the position with a read and a write-back per entry moved.
// Dump reads each entry and emits it as its own result.
// Reset empties the list; memory contents are not cleared.
// A stalled m_* side holds the sequencer; s_tready drops while busy.
module bounded_list_table import blt_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [ITEM_W-1:0]  s_tdata,  // value
	input  logic [CMD_W-1:0]   s_tuser,  // command
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // item_value, position, zero pad
	output logic [STAT_W-1:0]  m_tuser,  // status
	output logic               m_tlast
);

	localparam int AW = $clog2(CAPACITY);

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  res_ld;
	logic                  res_free;
	res_t                  res;

	blt_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	blt_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.value    (s_tdata),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rdata    (rdata),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.res_ld   (res_ld),
		.res      (res),
		.res_free (res_free)
	);

	blt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (res_ld),
		.res      (res),
		.free     (res_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== dv/tb_bounded_list_table.sv =====
`timescale 1ns / 1ps

module tb_bounded_list_table;
	import blt_pkg::*;

	localparam int LIST_CAP     = 16;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 340;
	localparam int STALL_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [ITEM_W-1:0]  s_tdata;
	logic [CMD_W-1:0]   s_tuser;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]  m_tuser;
	logic               m_tlast;

	// software copy of the list, head at index 0
	logic signed [ITEM_W-1:0] list_model[$];
	res_t                     pending_replies[$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int rx_hold_req    = 0;
	bit tx_steady      = 1'b0;
	bit rx_steady      = 1'b0;

	bounded_list_table #(
		.CAPACITY  (LIST_CAP),
		.DATA_WIDTH(ITEM_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void push_reply(logic [ITEM_W-1:0] v, int pos,
			logic [STAT_W-1:0] st, logic lst);
		res_t r;
		r.item_value = v;
		r.position   = pos[POS_W-1:0];
		r.status     = st;
		r.last       = lst;
		pending_replies.push_back(r);
	endfunction

	function automatic void apply_to_list(logic [CMD_W-1:0] cmd, logic signed [ITEM_W-1:0] v);
		int pos;
		int n;
		case (cmd)
			CMD_APPEND, CMD_INSERT: begin
				if (list_model.size() >= LIST_CAP) begin
					push_reply(v, 0, STAT_FULL, 1'b1);
				end else begin
					if (cmd == CMD_APPEND) begin
						pos = list_model.size();
					end else if (list_model.size() == 0 || list_model[0] > v) begin
						pos = 0;
					end else begin
						pos = 0;
						while (pos + 1 < list_model.size() && list_model[pos + 1] < v)
							pos++;
						pos = pos + 1;
					end
					list_model.insert(pos, v);
					push_reply(v, pos, STAT_OK, 1'b1);
				end
			end
			CMD_DELETE: begin
				pos = -1;
				foreach (list_model[i])
					if (pos < 0 && list_model[i] == v)
						pos = i;
				if (pos < 0) begin
					push_reply(v, 0, STAT_NOT_FOUND, 1'b1);
				end else begin
					list_model.delete(pos);
					push_reply(v, pos, STAT_OK, 1'b1);
				end
			end
			default: begin
				n = (list_model.size() < MAX_RESULTS) ? list_model.size() : MAX_RESULTS;
				if (n == 0)
					push_reply('0, 0, STAT_EMPTY, 1'b1);
				for (int i = 0; i < n; i++)
					push_reply(list_model[i], i, STAT_OK, i == n - 1);
			end
		endcase
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int gap_len(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ITEM_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2, 3, 4: return $urandom_range(0, 8) - 4;
			5:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ITEM_W-1:0] pick_delete_value();
		if (list_model.size() > 0 && $urandom_range(0, 3) != 0)
			return list_model[$urandom_range(0, list_model.size() - 1)];
		return pick_value();
	endfunction

	task automatic issue_cmd(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] v);
		int gap;
		gap = gap_len(tx_steady);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tuser  <= CMD_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_to_list(cmd, v);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		issue_cmd(CMD_DUMP, $urandom);
		issue_cmd(CMD_DELETE, 32'd5);
		issue_cmd(CMD_DELETE, 32'h8000_0000);
	endtask

	task automatic test_ordering_and_extremes();
		issue_cmd(CMD_INSERT, 32'h0);
		issue_cmd(CMD_INSERT, 32'h7FFF_FFFF);
		issue_cmd(CMD_INSERT, 32'h8000_0000);
		issue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
		issue_cmd(CMD_INSERT, 32'h0);
		issue_cmd(CMD_APPEND, 32'h5555_5555);
		issue_cmd(CMD_APPEND, 32'hAAAA_AAAA);
		issue_cmd(CMD_DUMP, 32'h0);
		issue_cmd(CMD_DELETE, 32'h0);
		issue_cmd(CMD_DELETE, 32'h7FFF_FFFF);
		issue_cmd(CMD_DELETE, 32'd123);
		issue_cmd(CMD_DELETE, 32'h8000_0000);
		issue_cmd(CMD_DUMP, 32'hFFFF_FFFF);
	endtask

	task automatic test_fill_to_capacity();
		while (list_model.size() > 0)
			issue_cmd(CMD_DELETE, list_model[0]);
		while (list_model.size() < LIST_CAP)
			issue_cmd($urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND, pick_value());
		issue_cmd(CMD_APPEND, pick_value());
		issue_cmd(CMD_INSERT, pick_value());
		issue_cmd(CMD_DUMP, $urandom);
		while (list_model.size() > 0)
			issue_cmd(CMD_DELETE, list_model[$urandom_range(0, list_model.size() - 1)]);
		issue_cmd(CMD_DUMP, $urandom);
	endtask

	// long output stall fills the pipe; then the sender waits for all replies
	task automatic test_output_stall();
		rx_hold_req = STALL_CYCLES;
		tx_steady   = 1'b1;
		issue_cmd(CMD_INSERT, pick_value());
		issue_cmd(CMD_INSERT, pick_value());
		issue_cmd(CMD_APPEND, pick_value());
		issue_cmd(CMD_DUMP, $urandom);
		issue_cmd(CMD_DELETE, pick_delete_value());
		issue_cmd(CMD_DUMP, $urandom);
		tx_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int r;
		logic [CMD_W-1:0] cmd;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 60 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 10)
				cmd = CMD_DUMP;
			else if (r < ((list_model.size() >= 12) ? 60 : 35))
				cmd = CMD_DELETE;
			else
				cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
			issue_cmd(cmd, (cmd == CMD_DELETE) ? pick_delete_value() : pick_value());
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin : rx_driver
		int gap;
		forever begin
			if (rx_hold_req > 0) begin
				gap = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				gap = gap_len(rx_steady);
			end
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	end

	function automatic void flag_mismatch(string what, res_t want, res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display({"%0t %s: exp value=%0d pos=%0d status=%0d last=%0b, ",
				"got value=%0d pos=%0d status=%0d last=%0b"},
				$realtime, what, $signed(want.item_value), want.position, want.status, want.last,
				$signed(got.item_value), got.position, got.status, got.last);
	endfunction

	always @(posedge clk) begin : reply_check
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.item_value = m_tdata[ITEM_W-1:0];
			got.position   = m_tdata[ITEM_W +: POS_W];
			got.status     = m_tuser;
			got.last       = m_tlast;
			if (pending_replies.size() == 0) begin
				flag_mismatch("unexpected transaction", '0, got);
			end else begin
				want = pending_replies.pop_front();
				if (got.item_value !== want.item_value || got.position !== want.position ||
						got.status !== want.status || got.last !== want.last)
					flag_mismatch("field mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_ordering_and_extremes();
		test_fill_to_capacity();
		test_output_stall();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (2 * LIST_CAP + 10) @(posedge clk);
		mismatch_count += pending_replies.size();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== bounded_list_table.f =====
+incdir+rtl
rtl/blt_pkg.sv
rtl/blt_mem.sv
rtl/blt_out.sv
rtl/blt_ctrl.sv
rtl/bounded_list_table.sv
dv/tb_bounded_list_table.sv
